// ===== rtl/epd_pkg.sv =====
// shared types, constants and widths of the encoder position pid drive
// no dependencies; used by every module of the block
package epd_pkg;

  // build-time sizing
  localparam int COUNT_BITS      = 32;
  localparam int ANGLE_FRAC_BITS = 8;

  // field widths
  localparam int CMD_W    = 2;
  localparam int ANG_W    = 24;
  localparam int ERR_W    = ANG_W + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int SUM_W    = ANGLE_FRAC_BITS + 8;
  localparam int DPC_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int TOL_W    = 16;
  localparam int SPEED_W  = 15;
  localparam int DIR_W    = 2;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // stream packing
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_ITEM_W  = ANG_W + DIR_W + SPEED_W + 1;
  localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

  // serial multiplier sizing
  localparam int DIGIT_W      = 4;
  localparam int MAG_DIGITS   = (COUNT_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int GAIN_DIGITS  = GAIN_W / DIGIT_W;
  localparam int MUL_W        = MAG_DIGITS * DIGIT_W;
  localparam int DIG_CNT_W    = $clog2(MAG_DIGITS + 1);
  localparam int ANG_PROD_W   = COUNT_BITS + DPC_W + 1;
  localparam int PID_W        = GAIN_W + DIFF_W + 2;
  localparam int ACC_W        = (ANG_PROD_W > PID_W) ? ANG_PROD_W : PID_W;

  // fixed point scaling
  localparam int ASHIFT      = 16 - ANGLE_FRAC_BITS;
  localparam int Q_W         = ACC_W - ASHIFT;
  localparam int SPD_FULL_W  = ACC_W - ANGLE_FRAC_BITS;
  localparam int SUM_LIMIT   = 100 << ANGLE_FRAC_BITS;
  localparam int ANG_POS_MAX = (1 << (ANG_W - 1)) - 1;
  localparam int ANG_NEG_MAG = 1 << (ANG_W - 1);

  // configuration reset values
  localparam logic [DPC_W-1:0]   DPC_RST       = DPC_W'(23593);
  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = GAIN_W'(512);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = GAIN_W'(26);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = GAIN_W'(128);
  localparam logic [TOL_W-1:0]   TOL_RST       = TOL_W'(512);
  localparam logic [SPEED_W-1:0] SPEED_MAX_RST = SPEED_W'(20480);
  localparam logic [SPEED_W-1:0] SPEED_MIN_RST = SPEED_W'(3840);

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_TARGET = 2'd2,
    CMD_ZERO   = 2'd3
  } cmd_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DPC       = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_TOL       = 3'd4,
    REG_SPEED_MAX = 3'd5,
    REG_SPEED_MIN = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANG_LD,
    S_ANG_RUN,
    S_RND,
    S_SAT,
    S_ERR,
    S_UPD,
    S_PID_LD,
    S_PID_RUN,
    S_SPD,
    S_LIM,
    S_DONE
  } state_t;

  // multiplier control from the sequencer
  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic [DIG_CNT_W-1:0] ndig;
  } mac_ctl_t;

  // one result item
  typedef struct packed {
    logic                    at_target;
    logic [SPEED_W-1:0]      speed;
    logic [DIR_W-1:0]        direction;
    logic signed [ANG_W-1:0] position;
  } out_item_t;

endpackage

// ===== rtl/epd_serial_mac.sv =====
// digit-serial multiply-accumulate: one 4-bit multiplier digit per cycle
// depends on epd_pkg
module epd_serial_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  epd_pkg::mac_ctl_t                    ctl,
  input  logic signed [epd_pkg::ACC_W-1:0]     mcand,
  input  logic        [epd_pkg::MUL_W-1:0]     mult,
  output logic signed [epd_pkg::ACC_W-1:0]     acc,
  output logic                                 busy
);

  logic signed [epd_pkg::ACC_W-1:0]     mcand_r;
  logic        [epd_pkg::MUL_W-1:0]     mult_r;
  logic        [epd_pkg::DIG_CNT_W-1:0] dig_r;
  logic signed [epd_pkg::ACC_W-1:0]     acc_r;
  logic        [epd_pkg::DIGIT_W-1:0]   digit;
  logic signed [epd_pkg::ACC_W-1:0]     partial;

  // partial product of the current digit
  assign digit   = mult_r[epd_pkg::DIGIT_W-1:0];
  assign partial = epd_pkg::ACC_W'(mcand_r * $signed({1'b0, digit}));
  assign busy    = (dig_r != '0);
  assign acc     = acc_r;

  // digit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r <= '0;
    end else if (ctl.load) begin
      dig_r <= ctl.ndig;
    end else if (busy) begin
      dig_r <= dig_r - 1'b1;
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r <= mcand;
      mult_r  <= mult;
      if (ctl.clear) begin
        acc_r <= '0;
      end
    end else if (busy) begin
      acc_r   <= acc_r + partial;
      mcand_r <= mcand_r <<< epd_pkg::DIGIT_W;
      mult_r  <= mult_r >> epd_pkg::DIGIT_W;
    end
  end

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !busy)
    else $error("multiplier loaded while still running");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load && ctl.ndig != '0) |=> busy)
    else $error("multiplier did not start after load");

endmodule

// ===== rtl/epd_out_reg.sv =====
// output register of the result stream, frees the core while a result waits
// depends on epd_pkg
module epd_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  epd_pkg::out_item_t                item,
  output logic                              free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // position[23:0], drive_direction[25:24], drive_speed[40:26], at_target[41]
  output logic [epd_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic               valid_r;
  logic               valid_nxt;
  epd_pkg::out_item_t item_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = epd_pkg::OUT_TDATA_W'(item_r);

  // valid flag
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_tready))
    else $error("pending result overwritten");

endmodule

// ===== rtl/encoder_position_pid_drive.sv =====
// top level: sequencer and datapath of the encoder position pid loop
// depends on epd_pkg, epd_serial_mac, epd_out_reg
// every request runs the angle product, rounding, saturation, error and update steps;
// a tick outside the tolerance band then runs the three pid gain terms and speed limits
// throughput: one request per item time, less while the output stalls; the 4-bit digit
// multiplier sets it (COUNT_BITS/4 steps for the angle, four for each gain term)
// reset: synchronous, clears count, target, integral, last error and held drive
module encoder_position_pid_drive (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // phase_a[0], phase_b[1], target_value[25:2]
  input  logic [epd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // command[1:0]
  input  logic [epd_pkg::IN_TUSER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // position[23:0], drive_direction[25:24], drive_speed[40:26], at_target[41]
  output logic [epd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [epd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [epd_pkg::CFG_W-1:0]            cfg_data
);

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  localparam logic signed [epd_pkg::ERR_W:0] SUM_HI = (epd_pkg::ERR_W + 1)'(epd_pkg::SUM_LIMIT);
  localparam logic signed [epd_pkg::ERR_W:0] SUM_LO = -SUM_HI;
  localparam logic [epd_pkg::ACC_W-1:0] ANG_HALF = epd_pkg::ACC_W'(1 << (epd_pkg::ASHIFT - 1));
  localparam logic [epd_pkg::ACC_W-1:0] SPD_HALF =
    epd_pkg::ACC_W'(1 << (epd_pkg::ANGLE_FRAC_BITS - 1));
  localparam logic [epd_pkg::Q_W-1:0] Q_POS_MAX = epd_pkg::Q_W'(epd_pkg::ANG_POS_MAX);
  localparam logic [epd_pkg::Q_W-1:0] Q_NEG_MAG = epd_pkg::Q_W'(epd_pkg::ANG_NEG_MAG);

  // configuration registers
  logic [epd_pkg::DPC_W-1:0]   dpc_r;
  logic [epd_pkg::GAIN_W-1:0]  gain_p_r;
  logic [epd_pkg::GAIN_W-1:0]  gain_i_r;
  logic [epd_pkg::GAIN_W-1:0]  gain_d_r;
  logic [epd_pkg::TOL_W-1:0]   tol_r;
  logic [epd_pkg::SPEED_W-1:0] speed_max_r;
  logic [epd_pkg::SPEED_W-1:0] speed_min_r;

  // loop state
  logic        [epd_pkg::COUNT_BITS-1:0] edge_count_r;
  logic signed [epd_pkg::ANG_W-1:0]      target_r;
  logic signed [epd_pkg::SUM_W-1:0]      esum_r;
  logic signed [epd_pkg::ERR_W-1:0]      last_err_r;
  epd_pkg::dir_t                         held_dir_r;
  logic        [epd_pkg::SPEED_W-1:0]    held_speed_r;

  // per-item working registers
  epd_pkg::state_t                       state_r;
  epd_pkg::state_t                       state_nxt;
  epd_pkg::cmd_t                         cmd_r;
  term_t                                 term_r;
  logic                                  neg_r;
  logic        [epd_pkg::Q_W-1:0]        q_r;
  logic signed [epd_pkg::ANG_W-1:0]      angle_r;
  logic signed [epd_pkg::ERR_W-1:0]      err_r;
  logic signed [epd_pkg::DIFF_W-1:0]     diff_r;
  logic                                  at_r;
  logic                                  far_r;
  logic        [epd_pkg::SPD_FULL_W-1:0] spd_r;
  logic                                  s_neg_r;
  logic                                  s_zero_r;

  // combinational helpers
  logic                                  in_accept;
  epd_pkg::cmd_t                         in_cmd;
  logic        [epd_pkg::COUNT_BITS-1:0] count_mag;
  logic        [epd_pkg::ERR_W-1:0]      abs_err;
  logic                                  near;
  logic signed [epd_pkg::ERR_W:0]        sum_ext;
  logic signed [epd_pkg::ERR_W:0]        sum_clamp;
  logic        [epd_pkg::ACC_W-1:0]      acc_u;
  logic        [epd_pkg::ACC_W-1:0]      ang_round;
  logic        [epd_pkg::ACC_W-1:0]      spd_round;
  logic        [epd_pkg::SPEED_W-1:0]    spd_cap;
  logic        [epd_pkg::SPEED_W-1:0]    spd_final;

  // multiplier and output register hookup
  epd_pkg::mac_ctl_t                     mac_ctl;
  logic signed [epd_pkg::ACC_W-1:0]      mac_mcand;
  logic        [epd_pkg::MUL_W-1:0]      mac_mult;
  logic signed [epd_pkg::ACC_W-1:0]      mac_acc;
  logic                                  mac_busy;
  logic                                  out_load;
  logic                                  out_free;
  epd_pkg::out_item_t                    out_item;

  epd_serial_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .mcand (mac_mcand),
    .mult  (mac_mult),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

  assign out_item.position  = angle_r;
  assign out_item.direction = held_dir_r;
  assign out_item.speed     = held_speed_r;
  assign out_item.at_target = at_r;

  epd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .item       (out_item),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign in_cmd    = epd_pkg::cmd_t'(in_tuser[epd_pkg::CMD_W-1:0]);
  assign in_accept = in_tvalid && in_tready;

  // magnitude of the count for the angle product
  assign count_mag = edge_count_r[epd_pkg::COUNT_BITS-1] ? (~edge_count_r + 1'b1)
                                                         : edge_count_r;

  // error magnitude and band tests
  assign abs_err = err_r[epd_pkg::ERR_W-1] ? epd_pkg::ERR_W'(-err_r)
                                           : epd_pkg::ERR_W'(err_r);
  assign near    = abs_err < epd_pkg::ERR_W'(tol_r);

  // integral update with clamp
  assign sum_ext = (epd_pkg::ERR_W + 1)'(esum_r) + (epd_pkg::ERR_W + 1)'(err_r);
  always_comb begin
    if (sum_ext > SUM_HI) begin
      sum_clamp = SUM_HI;
    end else if (sum_ext < SUM_LO) begin
      sum_clamp = SUM_LO;
    end else begin
      sum_clamp = sum_ext;
    end
  end

  // rounding of the products; a negative sum rounds as ~s + 1 + half
  assign acc_u     = $unsigned(mac_acc);
  assign ang_round = acc_u + ANG_HALF;
  assign spd_round = mac_acc[epd_pkg::ACC_W-1] ? (~acc_u + SPD_HALF + 1'b1)
                                               : (acc_u + SPD_HALF);

  // speed limits: maximum first, then the minimum when the error is above the tolerance
  always_comb begin
    if (spd_r > epd_pkg::SPD_FULL_W'(speed_max_r)) begin
      spd_cap = speed_max_r;
    end else begin
      spd_cap = spd_r[epd_pkg::SPEED_W-1:0];
    end
    if (spd_cap < speed_min_r && far_r) begin
      spd_final = speed_min_r;
    end else begin
      spd_final = spd_cap;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r       <= epd_pkg::DPC_RST;
      gain_p_r    <= epd_pkg::GAIN_P_RST;
      gain_i_r    <= epd_pkg::GAIN_I_RST;
      gain_d_r    <= epd_pkg::GAIN_D_RST;
      tol_r       <= epd_pkg::TOL_RST;
      speed_max_r <= epd_pkg::SPEED_MAX_RST;
      speed_min_r <= epd_pkg::SPEED_MIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        epd_pkg::REG_DPC:       dpc_r       <= cfg_data[epd_pkg::DPC_W-1:0];
        epd_pkg::REG_GAIN_P:    gain_p_r    <= cfg_data[epd_pkg::GAIN_W-1:0];
        epd_pkg::REG_GAIN_I:    gain_i_r    <= cfg_data[epd_pkg::GAIN_W-1:0];
        epd_pkg::REG_GAIN_D:    gain_d_r    <= cfg_data[epd_pkg::GAIN_W-1:0];
        epd_pkg::REG_TOL:       tol_r       <= cfg_data[epd_pkg::TOL_W-1:0];
        epd_pkg::REG_SPEED_MAX: speed_max_r <= cfg_data[epd_pkg::SPEED_W-1:0];
        epd_pkg::REG_SPEED_MIN: speed_min_r <= cfg_data[epd_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, multiplier control and handshakes
  always_comb begin
    state_nxt    = state_r;
    mac_ctl      = '0;
    mac_mcand    = '0;
    mac_mult     = '0;
    out_load     = 1'b0;
    in_tready    = 1'b0;
    case (state_r)
      epd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = epd_pkg::S_ANG_LD;
        end
      end
      epd_pkg::S_ANG_LD: begin
        mac_ctl.load  = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_ctl.ndig  = epd_pkg::DIG_CNT_W'(epd_pkg::MAG_DIGITS);
        mac_mcand     = epd_pkg::ACC_W'(dpc_r);
        mac_mult      = epd_pkg::MUL_W'(count_mag);
        state_nxt     = epd_pkg::S_ANG_RUN;
      end
      epd_pkg::S_ANG_RUN: begin
        if (!mac_busy) begin
          state_nxt = epd_pkg::S_RND;
        end
      end
      epd_pkg::S_RND: state_nxt = epd_pkg::S_SAT;
      epd_pkg::S_SAT: state_nxt = epd_pkg::S_ERR;
      epd_pkg::S_ERR: state_nxt = epd_pkg::S_UPD;
      epd_pkg::S_UPD: begin
        if (cmd_r == epd_pkg::CMD_TICK && !near) begin
          state_nxt = epd_pkg::S_PID_LD;
        end else begin
          state_nxt = epd_pkg::S_DONE;
        end
      end
      epd_pkg::S_PID_LD: begin
        mac_ctl.load = 1'b1;
        mac_ctl.ndig = epd_pkg::DIG_CNT_W'(epd_pkg::GAIN_DIGITS);
        case (term_r)
          TERM_P: begin
            mac_ctl.clear = 1'b1;
            mac_mcand     = epd_pkg::ACC_W'(err_r);
            mac_mult      = epd_pkg::MUL_W'(gain_p_r);
          end
          TERM_I: begin
            mac_mcand = epd_pkg::ACC_W'(esum_r);
            mac_mult  = epd_pkg::MUL_W'(gain_i_r);
          end
          default: begin
            mac_mcand = epd_pkg::ACC_W'(diff_r);
            mac_mult  = epd_pkg::MUL_W'(gain_d_r);
          end
        endcase
        state_nxt = epd_pkg::S_PID_RUN;
      end
      epd_pkg::S_PID_RUN: begin
        if (!mac_busy) begin
          if (term_r == TERM_D) begin
            state_nxt = epd_pkg::S_SPD;
          end else begin
            state_nxt = epd_pkg::S_PID_LD;
          end
        end
      end
      epd_pkg::S_SPD: state_nxt = epd_pkg::S_LIM;
      epd_pkg::S_LIM: state_nxt = epd_pkg::S_DONE;
      epd_pkg::S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = epd_pkg::S_IDLE;
        end
      end
      default: state_nxt = epd_pkg::S_IDLE;
    endcase
  end

  // loop state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      target_r     <= '0;
      esum_r       <= '0;
      last_err_r   <= '0;
      held_dir_r   <= epd_pkg::DIR_STOP;
      held_speed_r <= '0;
    end else begin
      case (state_r)
        epd_pkg::S_IDLE: begin
          if (in_accept) begin
            case (in_cmd)
              epd_pkg::CMD_EDGE: begin
                if (in_tdata[0] == in_tdata[1]) begin
                  edge_count_r <= edge_count_r + 1'b1;
                end else begin
                  edge_count_r <= edge_count_r - 1'b1;
                end
              end
              epd_pkg::CMD_TARGET: begin
                target_r <= $signed(in_tdata[epd_pkg::ANG_W+1:2]);
                esum_r   <= '0;
              end
              epd_pkg::CMD_ZERO: begin
                edge_count_r <= '0;
                target_r     <= '0;
                esum_r       <= '0;
                last_err_r   <= '0;
              end
              default: ;
            endcase
          end
        end
        epd_pkg::S_UPD: begin
          if (cmd_r == epd_pkg::CMD_TICK) begin
            if (near) begin
              held_dir_r   <= epd_pkg::DIR_STOP;
              held_speed_r <= '0;
            end else begin
              esum_r     <= epd_pkg::SUM_W'(sum_clamp);
              last_err_r <= err_r;
            end
          end
        end
        epd_pkg::S_LIM: begin
          if (s_zero_r) begin
            held_dir_r   <= epd_pkg::DIR_STOP;
            held_speed_r <= '0;
          end else begin
            held_dir_r   <= s_neg_r ? epd_pkg::DIR_BWD : epd_pkg::DIR_FWD;
            held_speed_r <= spd_final;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of one item
  always_ff @(posedge clk) begin
    case (state_r)
      epd_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_r <= in_cmd;
        end
        term_r <= TERM_P;
      end
      epd_pkg::S_ANG_LD: neg_r <= edge_count_r[epd_pkg::COUNT_BITS-1];
      epd_pkg::S_RND:    q_r   <= ang_round[epd_pkg::ACC_W-1:epd_pkg::ASHIFT];
      // saturate and apply the sign of the count
      epd_pkg::S_SAT: begin
        if (neg_r) begin
          angle_r <= (q_r > Q_NEG_MAG) ? epd_pkg::ANG_W'(Q_NEG_MAG) : epd_pkg::ANG_W'(-q_r);
        end else begin
          angle_r <= (q_r > Q_POS_MAX) ? epd_pkg::ANG_W'(Q_POS_MAX) : epd_pkg::ANG_W'(q_r);
        end
      end
      epd_pkg::S_ERR: err_r <= epd_pkg::ERR_W'(target_r) - epd_pkg::ERR_W'(angle_r);
      epd_pkg::S_UPD: begin
        at_r   <= near;
        far_r  <= abs_err > epd_pkg::ERR_W'(tol_r);
        diff_r <= epd_pkg::DIFF_W'(err_r) - epd_pkg::DIFF_W'(last_err_r);
      end
      epd_pkg::S_PID_RUN: begin
        if (!mac_busy) begin
          case (term_r)
            TERM_P:  term_r <= TERM_I;
            TERM_I:  term_r <= TERM_D;
            default: term_r <= TERM_D;
          endcase
        end
      end
      epd_pkg::S_SPD: begin
        s_zero_r <= (mac_acc == '0);
        s_neg_r  <= mac_acc[epd_pkg::ACC_W-1];
        spd_r    <= spd_round[epd_pkg::ACC_W-1:epd_pkg::ANGLE_FRAC_BITS];
      end
      default: ;
    endcase
  end

  a_stop_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    held_dir_r == epd_pkg::DIR_STOP |-> held_speed_r == '0)
    else $error("stopped drive with nonzero speed");

  a_band_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epd_pkg::S_DONE && cmd_r == epd_pkg::CMD_TICK && at_r)
      |-> held_dir_r == epd_pkg::DIR_STOP)
    else $error("tick inside the band left the drive running");

endmodule
